@@ design/dvg_pkg.sv @@
// Package for the dotted version gate.
// Holds the parse phase type, order codes, character constants and the
// structs passed between the top level and the parse core. No dependencies.
package dvg_pkg;

   localparam int MAX_PARTS_DEF = 4;
   localparam int NUM_MIN_PARTS = 4;

   localparam int CH_W    = 8;
   localparam int PART_W  = 32;
   localparam int ACC_W   = 36;
   localparam int COUNT_W = 3;
   localparam int ORDER_W = 2;

   localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
   localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE = 8'h39;
   localparam logic [CH_W-1:0] CH_DOT  = 8'h2E;

   localparam logic [ORDER_W-1:0] ORD_LESS    = 2'b11;
   localparam logic [ORDER_W-1:0] ORD_EQUAL   = 2'b00;
   localparam logic [ORDER_W-1:0] ORD_GREATER = 2'b01;

   localparam logic [2:0] REG_MIN_COUNT = 3'd0;
   localparam logic [2:0] REG_MIN_PART0 = 3'd1;
   localparam logic [2:0] REG_MIN_PART1 = 3'd2;
   localparam logic [2:0] REG_MIN_PART2 = 3'd3;
   localparam logic [2:0] REG_MIN_PART3 = 3'd4;

   typedef enum logic [1:0] {
      PH_DIGITS = 2'd0,
      PH_SKIP   = 2'd1,
      PH_DONE   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [COUNT_W-1:0]                   min_count;
      logic [NUM_MIN_PARTS-1:0][PART_W-1:0] min_part;
   } cfg_type;

   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic               accept;
      logic [COUNT_W-1:0] parts_seen;
   } result_type;

endpackage

@@ design/dvg_core.sv @@
// Parse core of the dotted version gate: per-string parse state and the
// one-character update with part commit and final compare.
// Depends on dvg_pkg.
module dvg_core #(
   parameter int MAX_PARTS = dvg_pkg::MAX_PARTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  logic [dvg_pkg::CH_W-1:0]    step_ch,
   input  logic                        step_last,
   input  dvg_pkg::cfg_type            cfg,
   output dvg_pkg::result_type         result
);

   localparam logic [dvg_pkg::COUNT_W-1:0] MAXP = dvg_pkg::COUNT_W'(MAX_PARTS);
   localparam logic [dvg_pkg::ACC_W-1:0]   ACC_LIMIT = {4'h0, 32'hFFFF_FFFF};

   dvg_pkg::phase_type                phase_ff, phase_in, phase_t;
   logic [dvg_pkg::ACC_W-1:0]         acc_ff, acc_in, acc_t, acc_mul;
   logic                              ds_ff, ds_in, ds_t;
   logic [dvg_pkg::COUNT_W-1:0]       pc_ff, pc_in, pc_t;
   logic [dvg_pkg::ORDER_W-1:0]       ord_ff, ord_in, ord_t, ord_f;
   logic                              any_ff, any_in, any_t;
   logic                              is_digit, is_dot, is_nul, commit;
   logic [dvg_pkg::COUNT_W-1:0]       mc;
   logic [dvg_pkg::PART_W-1:0]        part_val, min_val;

   always_comb begin
      mc = (cfg.min_count > MAXP) ? MAXP : cfg.min_count;
      is_digit = (step_ch >= dvg_pkg::CH_ZERO) && (step_ch <= dvg_pkg::CH_NINE);
      is_dot   = (step_ch == dvg_pkg::CH_DOT);
      is_nul   = (step_ch == dvg_pkg::CH_NUL);
      // times ten as shift-and-add, plus the digit
      acc_mul = (acc_ff << 3) + (acc_ff << 1) + {32'h0, step_ch[3:0]};

      phase_t = phase_ff;
      acc_t   = acc_ff;
      ds_t    = ds_ff;
      commit  = 1'b0;
      any_t   = any_ff;

      unique case (phase_ff)
         dvg_pkg::PH_DIGITS: begin
            any_t = any_ff | ~is_nul;
            if (is_digit) begin
               if (acc_ff <= ACC_LIMIT) acc_t = acc_mul;
               ds_t   = 1'b1;
               commit = step_last;
            end else if (!ds_ff) begin
               phase_t = dvg_pkg::PH_DONE;
            end else begin
               commit = 1'b1;
               if (is_dot)      phase_t = dvg_pkg::PH_DIGITS;
               else if (is_nul) phase_t = dvg_pkg::PH_DONE;
               else             phase_t = dvg_pkg::PH_SKIP;
            end
         end
         dvg_pkg::PH_SKIP: begin
            any_t = any_ff | ~is_nul;
            if (is_dot) begin
               phase_t = dvg_pkg::PH_DIGITS;
               acc_t   = '0;
               ds_t    = 1'b0;
            end else if (is_nul) begin
               phase_t = dvg_pkg::PH_DONE;
            end
         end
         default: begin
            // done: ignore bytes until last
         end
      endcase

      part_val = (acc_t[dvg_pkg::ACC_W-1:dvg_pkg::PART_W] != '0) ? '1
               : acc_t[dvg_pkg::PART_W-1:0];
      min_val  = cfg.min_part[pc_ff[1:0]];
      pc_t  = pc_ff;
      ord_t = ord_ff;
      if (commit) begin
         if (pc_ff < MAXP) begin
            if ((ord_ff == dvg_pkg::ORD_EQUAL) && (pc_ff < mc)) begin
               if (part_val < min_val)      ord_t = dvg_pkg::ORD_LESS;
               else if (part_val > min_val) ord_t = dvg_pkg::ORD_GREATER;
            end
            pc_t = pc_ff + 3'd1;
         end
         acc_t = '0;
         ds_t  = 1'b0;
      end

      // shorter prefix counts as smaller
      ord_f = ord_t;
      if (ord_t == dvg_pkg::ORD_EQUAL) begin
         if (pc_t < mc)      ord_f = dvg_pkg::ORD_LESS;
         else if (pc_t > mc) ord_f = dvg_pkg::ORD_GREATER;
      end

      result.order      = ord_f;
      result.accept     = ~any_t | (mc == '0) | (ord_f != dvg_pkg::ORD_LESS);
      result.parts_seen = pc_t;

      // a finished string returns the parse state to its reset values
      if (step_last) begin
         phase_in = dvg_pkg::PH_DIGITS;
         acc_in   = '0;
         ds_in    = 1'b0;
         pc_in    = '0;
         ord_in   = dvg_pkg::ORD_EQUAL;
         any_in   = 1'b0;
      end else begin
         phase_in = phase_t;
         acc_in   = acc_t;
         ds_in    = ds_t;
         pc_in    = pc_t;
         ord_in   = ord_t;
         any_in   = any_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dvg_pkg::PH_DIGITS;
         acc_ff   <= '0;
         ds_ff    <= 1'b0;
         pc_ff    <= '0;
         ord_ff   <= dvg_pkg::ORD_EQUAL;
         any_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         ds_ff    <= ds_in;
         pc_ff    <= pc_in;
         ord_ff   <= ord_in;
         any_ff   <= any_in;
      end
   end

endmodule

@@ design/dotted_version_gate_top.sv @@
// Top level of the dotted version gate: stream channels, input register,
// result register and APB-style register block. Depends on dvg_pkg, dvg_core.
//
// Usage:
//   req_*  : one byte of the version string per transaction; tdata[7:0] is
//            the character (0 terminates), tlast marks the final byte.
//   rsp_*  : one result transaction per string, after its tlast byte.
//   csr_*  : minimum version: min_count at 0x00, min_part0..3 at 0x04..0x10.
//            Write only while no string is in flight; pready is always high.
// Throughput is one byte per cycle while no last byte waits for the result
// register; every byte passes through an input register, one combinational
// parse/compare step and, for the last byte, the result register. The tlast
// byte goes from the input register into the result register, which drives rsp_tvalid.
// When rsp_tready is low the result is held; the input register still takes
// bytes of the next string, and only a second tlast byte waits for the
// result register to empty.
// Reset (synchronous) empties both registers, clears the parse state and
// sets all configuration registers to zero, which disables the gate.
module dotted_version_gate_top #(
   parameter int MAX_PARTS = dvg_pkg::MAX_PARTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] ch
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   // rsp_tdata: [1:0] order, [2] accept, [5:3] parts_seen, [7:6] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   dvg_pkg::cfg_type    cfg_ff;
   dvg_pkg::result_type step_result, rsp_data_ff;
   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_ch_ff;
   logic                s1_last_ff;
   logic                s1_adv, req_accept;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                csr_write;
   logic [2:0]          csr_index;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            dvg_pkg::REG_MIN_COUNT: cfg_ff.min_count   <= csr_pwdata[2:0];
            dvg_pkg::REG_MIN_PART0: cfg_ff.min_part[0] <= csr_pwdata;
            dvg_pkg::REG_MIN_PART1: cfg_ff.min_part[1] <= csr_pwdata;
            dvg_pkg::REG_MIN_PART2: cfg_ff.min_part[2] <= csr_pwdata;
            dvg_pkg::REG_MIN_PART3: cfg_ff.min_part[3] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         dvg_pkg::REG_MIN_COUNT: csr_prdata = {29'h0, cfg_ff.min_count};
         dvg_pkg::REG_MIN_PART0: csr_prdata = cfg_ff.min_part[0];
         dvg_pkg::REG_MIN_PART1: csr_prdata = cfg_ff.min_part[1];
         dvg_pkg::REG_MIN_PART2: csr_prdata = cfg_ff.min_part[2];
         dvg_pkg::REG_MIN_PART3: csr_prdata = cfg_ff.min_part[3];
         default:                csr_prdata = '0;
      endcase
   end

   // ---------------- input register ----------------
   // a last byte advances only when the result register can take it
   assign s1_adv     = s1_valid_ff & (~s1_last_ff | ~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_adv;
   assign req_accept = req_tvalid & req_tready;
   assign s1_valid_in = req_accept | (s1_valid_ff & ~s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ch_ff   <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   // ---------------- parse core ----------------
   dvg_core #(
      .MAX_PARTS (MAX_PARTS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (s1_adv),
      .step_ch   (s1_ch_ff),
      .step_last (s1_last_ff),
      .cfg       (cfg_ff),
      .result    (step_result)
   );

   // ---------------- result register ----------------
   always_comb begin
      if (s1_adv && s1_last_ff) rsp_valid_in = 1'b1;
      else if (rsp_tready)      rsp_valid_in = 1'b0;
      else                      rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_last_ff) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff.parts_seen, rsp_data_ff.accept,
                        rsp_data_ff.order};

`ifndef SYNTHESIS
   a_accept_when_not_less: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.order != dvg_pkg::ORD_LESS) |-> rsp_data_ff.accept)
      else $error("result rejected although order is not less");

   a_parts_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.parts_seen <= 3'(MAX_PARTS)))
      else $error("parts_seen beyond MAX_PARTS");

   a_gate_disabled: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_last_ff && (cfg_ff.min_count == '0) |=> rsp_data_ff.accept)
      else $error("disabled gate produced a reject");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_ch_ff) && $stable(s1_last_ff))
      else $error("pending input byte was overwritten");
`endif

endmodule

@@ verif/dotted_version_gate_top_test.sv @@
// Testbench for dotted_version_gate_top: streams version strings byte by byte, predicts
// each verdict with a local parse/compare model and checks the order, accept and parts_seen fields.
// Depends on dvg_pkg and the gate RTL (dotted_version_gate_top).
module dotted_version_gate_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          PARTS_KEPT = dvg_pkg::MAX_PARTS_DEF;
   localparam logic [35:0] PART_LIMIT = 36'h0_FFFF_FFFF;

   typedef logic [7:0] byte_queue_type[$];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;     // [7:0] ch
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [1:0] order, [2] accept, [5:3] parts_seen, [7:6] zero
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int req_gap_max = 3;
   int rsp_stall_max = 3;
   int mismatch_count = 0;

   // shadow of the minimum-version registers
   logic [2:0]  gate_count;
   logic [31:0] gate_part[dvg_pkg::NUM_MIN_PARTS];

   // parse state of the string in flight
   dvg_pkg::phase_type scan_phase;
   logic [35:0]        scan_value;
   logic               scan_digit;
   logic [2:0]         scan_parts;
   logic [1:0]         scan_order;
   logic               scan_nonempty;

   dvg_pkg::result_type verdict_queue[$];

   dotted_version_gate_top DUT (.*);

   always #4 clock = ~clock;

   function automatic logic [2:0] gate_parts();
      return (gate_count > PARTS_KEPT) ? 3'(PARTS_KEPT) : gate_count;
   endfunction

   function automatic void clear_scan();
      scan_phase = dvg_pkg::PH_DIGITS;
      scan_value = '0;
      scan_digit = 1'b0;
      scan_parts = '0;
      scan_order = dvg_pkg::ORD_EQUAL;
      scan_nonempty = 1'b0;
   endfunction

   function automatic void close_part();
      logic [31:0] value;
      logic [31:0] floor_value;
      if (scan_parts < PARTS_KEPT) begin
         value = (scan_value > PART_LIMIT) ? 32'hFFFF_FFFF : scan_value[31:0];
         if (scan_order == dvg_pkg::ORD_EQUAL && scan_parts < gate_parts()) begin
            floor_value = gate_part[scan_parts[1:0]];
            if (value < floor_value)
               scan_order = dvg_pkg::ORD_LESS;
            else if (value > floor_value)
               scan_order = dvg_pkg::ORD_GREATER;
         end
         scan_parts = scan_parts + 3'd1;
      end
      scan_value = '0;
      scan_digit = 1'b0;
   endfunction

   // advance the parse state by one byte; on the last byte queue the verdict
   function automatic void predict_byte(logic [7:0] ch, logic last);
      dvg_pkg::result_type verdict;
      logic [2:0]          needed;
      if (scan_phase == dvg_pkg::PH_DIGITS || scan_phase == dvg_pkg::PH_SKIP) begin
         if (ch != dvg_pkg::CH_NUL)
            scan_nonempty = 1'b1;
         if (scan_phase == dvg_pkg::PH_DIGITS) begin
            if (ch >= dvg_pkg::CH_ZERO && ch <= dvg_pkg::CH_NINE) begin
               if (scan_value <= PART_LIMIT)
                  scan_value = scan_value * 36'd10 + 36'(ch - dvg_pkg::CH_ZERO);
               scan_digit = 1'b1;
            end else if (!scan_digit) begin
               scan_phase = dvg_pkg::PH_DONE;
            end else begin
               close_part();
               if (ch == dvg_pkg::CH_DOT)
                  scan_phase = dvg_pkg::PH_DIGITS;
               else if (ch == dvg_pkg::CH_NUL)
                  scan_phase = dvg_pkg::PH_DONE;
               else
                  scan_phase = dvg_pkg::PH_SKIP;
            end
         end else if (ch == dvg_pkg::CH_DOT) begin
            scan_phase = dvg_pkg::PH_DIGITS;
            scan_value = '0;
            scan_digit = 1'b0;
         end else if (ch == dvg_pkg::CH_NUL) begin
            scan_phase = dvg_pkg::PH_DONE;
         end
      end
      if (last) begin
         if (scan_phase == dvg_pkg::PH_DIGITS && scan_digit)
            close_part();
         needed = gate_parts();
         verdict.order = scan_order;
         if (verdict.order == dvg_pkg::ORD_EQUAL) begin
            if (scan_parts < needed)
               verdict.order = dvg_pkg::ORD_LESS;
            else if (scan_parts > needed)
               verdict.order = dvg_pkg::ORD_GREATER;
         end
         verdict.accept = !scan_nonempty || needed == 3'd0 ||
                          verdict.order != dvg_pkg::ORD_LESS;
         verdict.parts_seen = scan_parts;
         verdict_queue.push_back(verdict);
         clear_scan();
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : check_results
      dvg_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_queue.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_tdata), 32'd0);
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_tdata[1:0] !== want.order)
               report_mismatch("order", 32'(rsp_tdata[1:0]), 32'(want.order));
            if (rsp_tdata[2] !== want.accept)
               report_mismatch("accept", 32'(rsp_tdata[2]), 32'(want.accept));
            if (rsp_tdata[5:3] !== want.parts_seen)
               report_mismatch("parts_seen", 32'(rsp_tdata[5:3]), 32'(want.parts_seen));
         end
      end
   end

   // result side: hold rsp_tready low for a random stall before taking each transaction
   initial begin : result_ready
      int stall;
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         repeat (stall) @(negedge clock) rsp_tready <= 1'b0;
         @(negedge clock) rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic send_byte(logic [7:0] ch, logic last);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      repeat (gap) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predict_byte(ch, last);
   endtask

   task automatic send_bytes(input byte_queue_type text);
      for (int i = 0; i < text.size(); i++)
         send_byte(text[i], i == text.size() - 1);
   endtask

   // drop valid and hold until every pending verdict has come back
   task automatic wait_drained();
      @(negedge clock) req_tvalid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == dvg_pkg::REG_MIN_COUNT)
         gate_count = value[2:0];
      else
         gate_part[2'(index - dvg_pkg::REG_MIN_PART0)] = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_minimum(logic [2:0] parts_needed, logic [31:0] p0, logic [31:0] p1,
                              logic [31:0] p2, logic [31:0] p3);
      wait_drained();
      write_reg(dvg_pkg::REG_MIN_COUNT, {29'd0, parts_needed});
      write_reg(dvg_pkg::REG_MIN_PART0, p0);
      write_reg(dvg_pkg::REG_MIN_PART1, p1);
      write_reg(dvg_pkg::REG_MIN_PART2, p2);
      write_reg(dvg_pkg::REG_MIN_PART3, p3);
   endtask

   function automatic byte_queue_type text_bytes(string text);
      byte_queue_type q;
      for (int i = 0; i < text.len(); i++)
         q.push_back(text[i]);
      return q;
   endfunction

   // any byte that is neither a digit, a dot nor the terminator
   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(1, 255));
      while (b == dvg_pkg::CH_DOT || (b >= dvg_pkg::CH_ZERO && b <= dvg_pkg::CH_NINE));
      return b;
   endfunction

   function automatic logic [31:0] random_part();
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2, 3, 4: return 32'($urandom_range(0, 20));
         default: return $urandom;
      endcase
   endfunction

   // mostly well-formed versions near the minimum, with some noise and broken strings
   function automatic byte_queue_type make_version();
      byte_queue_type q;
      int             shape;
      int             n_parts;
      int             n;
      logic [31:0]    value;
      string          digits;
      shape = $urandom_range(0, 19);
      if (shape == 0) begin
         n = $urandom_range(1, 8);
         repeat (n) q.push_back(8'($urandom_range(0, 255)));
         return q;
      end
      if (shape == 1) begin
         q.push_back(dvg_pkg::CH_NUL);
         return q;
      end
      n_parts = $urandom_range(1, 6);
      for (int i = 0; i < n_parts; i++) begin
         if (i != 0)
            q.push_back(dvg_pkg::CH_DOT);
         if (shape == 2 && i == n_parts - 1)
            q.push_back(junk_byte());
         if ($urandom_range(0, 9) == 0)
            q.push_back(dvg_pkg::CH_ZERO);
         case ($urandom_range(0, 9))
            0, 1, 2: value = gate_part[2'(i)];
            3:       value = gate_part[2'(i)] - 32'd1;
            4:       value = gate_part[2'(i)] + 32'd1;
            5, 6, 7: value = 32'($urandom_range(0, 20));
            default: value = $urandom;
         endcase
         if ($urandom_range(0, 11) == 0) begin
            // long run of digits, often past the 32-bit ceiling
            n = $urandom_range(10, 12);
            repeat (n) q.push_back(8'(dvg_pkg::CH_ZERO + $urandom_range(0, 9)));
         end else begin
            digits = $sformatf("%0d", value);
            for (int k = 0; k < digits.len(); k++)
               q.push_back(digits[k]);
         end
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) q.push_back(junk_byte());
         end
      end
      case ($urandom_range(0, 9))
         0: q.push_back(dvg_pkg::CH_DOT);
         1: begin
            q.push_back(dvg_pkg::CH_NUL);
            n = $urandom_range(0, 3);
            repeat (n) q.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      return q;
   endfunction

   task automatic test_directed();
      byte_queue_type q;
      req_gap_max = 3;
      rsp_stall_max = 3;
      // gate disabled out of reset
      send_bytes(text_bytes("7"));
      q = {};
      q.push_back(dvg_pkg::CH_NUL);
      send_bytes(q);
      set_minimum(3'd2, 32'd1, 32'd2, 32'd0, 32'hFFFF_FFFF);
      send_bytes(text_bytes("1.2"));
      send_bytes(text_bytes("1.1"));
      send_bytes(text_bytes("1"));
      send_bytes(q);
      send_bytes(text_bytes("x"));
      send_bytes(text_bytes("1a.3"));
      q = text_bytes("1");
      q.push_back(dvg_pkg::CH_NUL);
      q.push_back("9");
      send_bytes(q);
      // oversized count with saturating first part
      set_minimum(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_bytes(text_bytes("99999999999"));
   endtask

   task automatic test_pause_mid_string();
      req_gap_max = 0;
      rsp_stall_max = 8;
      send_bytes(text_bytes("2.0"));
      send_bytes(text_bytes("1.5"));
      send_byte("3", 1'b0);
      send_byte(dvg_pkg::CH_DOT, 1'b0);
      wait_drained();
      send_byte("1", 1'b0);
      send_byte("4", 1'b1);
   endtask

   task automatic test_random_strings(int target_bytes);
      byte_queue_type q;
      int             sent;
      int             phase_bytes;
      int             phase_no;
      sent = 0;
      phase_no = 0;
      while (sent < target_bytes) begin
         case (phase_no % 8)
            0: set_minimum(3'd0, random_part(), random_part(), random_part(), random_part());
            1: set_minimum(3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF);
            2: set_minimum(3'd4, 32'd0, 32'd0, 32'd0, 32'd0);
            3: set_minimum(3'd7, random_part(), random_part(), random_part(), random_part());
            4: set_minimum(3'd1, random_part(), random_part(), random_part(), random_part());
            default: set_minimum(3'($urandom_range(0, 7)), random_part(), random_part(),
                                 random_part(), random_part());
         endcase
         case (phase_no % 3)
            0: begin
               req_gap_max = 0;
               rsp_stall_max = 0;
            end
            1: begin
               req_gap_max = 8;
               rsp_stall_max = 8;
            end
            default: begin
               req_gap_max = $urandom_range(0, 8);
               rsp_stall_max = $urandom_range(0, 8);
            end
         endcase
         phase_bytes = 0;
         while (phase_bytes < 190 && sent < target_bytes) begin
            q = make_version();
            send_bytes(q);
            sent += q.size();
            phase_bytes += q.size();
         end
         phase_no++;
      end
   endtask

   initial begin
      clear_scan();
      gate_count = '0;
      for (int i = 0; i < dvg_pkg::NUM_MIN_PARTS; i++)
         gate_part[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_directed();
      test_pause_mid_string();
      test_random_strings(1850);
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && verdict_queue.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ sim.f @@
design/dvg_pkg.sv
design/dvg_core.sv
design/dotted_version_gate_top.sv
verif/dotted_version_gate_top_test.sv
